// ===== design/qfk_pkg.sv =====
`timescale 1ns / 1ps
package qfk_pkg;

	// Controller states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CORD = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	localparam int          CORDIC_STEPS = 30;
	localparam logic [4:0]  CORDIC_LAST  = 5'(CORDIC_STEPS - 1);
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// Shift-add multiplier: operand A is 36 bits, operand B 33 bits.
	localparam int         AW      = 36;
	localparam int         BW      = 33;
	localparam int         PW      = AW + BW;
	localparam int         ACCW    = 42;
	localparam logic [5:0] MUL_FIN = 6'(BW + 1);
	localparam logic [5:0] LAST_UOP = 6'd51;

	typedef logic signed [AW-1:0] w36_t;

	// Operand sources.
	localparam logic [4:0] S_CX = 5'd0, S_SX = 5'd1, S_CY = 5'd2, S_SY = 5'd3;
	localparam logic [4:0] S_CZ = 5'd4, S_SZ = 5'd5;
	localparam logic [4:0] S_CZCY = 5'd6, S_SZSY = 5'd7, S_CZSY = 5'd8, S_SZCY = 5'd9;
	localparam logic [4:0] S_D0 = 5'd10, S_D1 = 5'd11, S_D2 = 5'd12, S_D3 = 5'd13;
	localparam logic [4:0] S_Q0 = 5'd14, S_Q1 = 5'd15, S_Q2 = 5'd16, S_Q3 = 5'd17;
	localparam logic [4:0] S_N1 = 5'd18, S_N2 = 5'd19, S_N3 = 5'd20;
	localparam logic [4:0] S_V0 = 5'd21, S_V1 = 5'd22, S_V2 = 5'd23;
	localparam logic [4:0] S_T0 = 5'd24, S_T1 = 5'd25, S_T2 = 5'd26, S_T3 = 5'd27;

	// Destinations of a finished sum.
	localparam logic [4:0] D_CZCY = 5'd0, D_SZSY = 5'd1, D_CZSY = 5'd2, D_SZCY = 5'd3;
	localparam logic [4:0] D_D0 = 5'd4, D_D1 = 5'd5, D_D2 = 5'd6, D_D3 = 5'd7;
	localparam logic [4:0] D_NQ0 = 5'd8, D_NQ1 = 5'd9, D_NQ2 = 5'd10, D_ROT = 5'd11;
	localparam logic [4:0] D_T0 = 5'd12, D_T1 = 5'd13, D_T2 = 5'd14, D_T3 = 5'd15;
	localparam logic [4:0] D_P0 = 5'd16, D_P1 = 5'd17, D_P2 = 5'd18;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;
	localparam logic MID    = 1'b0;
	localparam logic LAST   = 1'b1;

	typedef struct packed {
		logic [4:0] srca;
		logic [4:0] srcb;
		logic       sub;
		logic       last;
		logic [4:0] dst;
	} uop_t;

	function automatic uop_t mk(input logic [4:0] a, input logic [4:0] b, input logic s,
			input logic l, input logic [4:0] d);
		uop_t u;
		u.srca = a;
		u.srcb = b;
		u.sub  = s;
		u.last = l;
		u.dst  = d;
		return u;
	endfunction

	// Product sequence of one joint item.
	function automatic uop_t uop_rom(input logic [5:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = mk(S_CZ, S_CY, OP_ADD, LAST, D_CZCY);
			6'd1:  u = mk(S_SZ, S_SY, OP_ADD, LAST, D_SZSY);
			6'd2:  u = mk(S_CZ, S_SY, OP_ADD, LAST, D_CZSY);
			6'd3:  u = mk(S_SZ, S_CY, OP_ADD, LAST, D_SZCY);
			6'd4:  u = mk(S_CZCY, S_CX, OP_ADD, MID, D_D0);
			6'd5:  u = mk(S_SZSY, S_SX, OP_ADD, LAST, D_D0);
			6'd6:  u = mk(S_CZCY, S_SX, OP_ADD, MID, D_D1);
			6'd7:  u = mk(S_SZSY, S_CX, OP_SUB, LAST, D_D1);
			6'd8:  u = mk(S_CZSY, S_CX, OP_ADD, MID, D_D2);
			6'd9:  u = mk(S_SZCY, S_SX, OP_ADD, LAST, D_D2);
			6'd10: u = mk(S_SZCY, S_CX, OP_ADD, MID, D_D3);
			6'd11: u = mk(S_CZSY, S_SX, OP_SUB, LAST, D_D3);
			6'd12: u = mk(S_Q0, S_D0, OP_ADD, MID, D_NQ0);
			6'd13: u = mk(S_Q1, S_D1, OP_SUB, MID, D_NQ0);
			6'd14: u = mk(S_Q2, S_D2, OP_SUB, MID, D_NQ0);
			6'd15: u = mk(S_Q3, S_D3, OP_SUB, LAST, D_NQ0);
			6'd16: u = mk(S_Q0, S_D1, OP_ADD, MID, D_NQ1);
			6'd17: u = mk(S_Q1, S_D0, OP_ADD, MID, D_NQ1);
			6'd18: u = mk(S_Q2, S_D3, OP_ADD, MID, D_NQ1);
			6'd19: u = mk(S_Q3, S_D2, OP_SUB, LAST, D_NQ1);
			6'd20: u = mk(S_Q0, S_D2, OP_ADD, MID, D_NQ2);
			6'd21: u = mk(S_Q1, S_D3, OP_SUB, MID, D_NQ2);
			6'd22: u = mk(S_Q2, S_D0, OP_ADD, MID, D_NQ2);
			6'd23: u = mk(S_Q3, S_D1, OP_ADD, LAST, D_NQ2);
			6'd24: u = mk(S_Q0, S_D3, OP_ADD, MID, D_ROT);
			6'd25: u = mk(S_Q1, S_D2, OP_ADD, MID, D_ROT);
			6'd26: u = mk(S_Q2, S_D1, OP_SUB, MID, D_ROT);
			6'd27: u = mk(S_Q3, S_D0, OP_ADD, LAST, D_ROT);
			6'd28: u = mk(S_Q1, S_V0, OP_SUB, MID, D_T0);
			6'd29: u = mk(S_Q2, S_V1, OP_SUB, MID, D_T0);
			6'd30: u = mk(S_Q3, S_V2, OP_SUB, LAST, D_T0);
			6'd31: u = mk(S_Q0, S_V0, OP_ADD, MID, D_T1);
			6'd32: u = mk(S_Q2, S_V2, OP_ADD, MID, D_T1);
			6'd33: u = mk(S_Q3, S_V1, OP_SUB, LAST, D_T1);
			6'd34: u = mk(S_Q0, S_V1, OP_ADD, MID, D_T2);
			6'd35: u = mk(S_Q1, S_V2, OP_SUB, MID, D_T2);
			6'd36: u = mk(S_Q3, S_V0, OP_ADD, LAST, D_T2);
			6'd37: u = mk(S_Q0, S_V2, OP_ADD, MID, D_T3);
			6'd38: u = mk(S_Q1, S_V1, OP_ADD, MID, D_T3);
			6'd39: u = mk(S_Q2, S_V0, OP_SUB, LAST, D_T3);
			6'd40: u = mk(S_T0, S_N1, OP_ADD, MID, D_P0);
			6'd41: u = mk(S_T1, S_Q0, OP_ADD, MID, D_P0);
			6'd42: u = mk(S_T2, S_N3, OP_ADD, MID, D_P0);
			6'd43: u = mk(S_T3, S_N2, OP_SUB, LAST, D_P0);
			6'd44: u = mk(S_T0, S_N2, OP_ADD, MID, D_P1);
			6'd45: u = mk(S_T1, S_N3, OP_SUB, MID, D_P1);
			6'd46: u = mk(S_T2, S_Q0, OP_ADD, MID, D_P1);
			6'd47: u = mk(S_T3, S_N1, OP_ADD, LAST, D_P1);
			6'd48: u = mk(S_T0, S_N3, OP_ADD, MID, D_P2);
			6'd49: u = mk(S_T1, S_N2, OP_ADD, MID, D_P2);
			6'd50: u = mk(S_T2, S_N1, OP_SUB, MID, D_P2);
			6'd51: u = mk(S_T3, S_Q0, OP_ADD, LAST, D_P2);
			default: u = mk(S_CX, S_CX, OP_ADD, MID, D_D0);
		endcase
		return u;
	endfunction

	// Arctangent of 2^-i as a fraction of a turn, 2^32 per turn.
	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'h20000000; 5'd1:  a = 32'h12E4051E; 5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4; 5'd4:  a = 32'h028B0D43; 5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E; 5'd7:  a = 32'h00517C55; 5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F; 5'd10: a = 32'h000A2F98; 5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6; 5'd13: a = 32'h000145F3; 5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D; 5'd16: a = 32'h000028BE; 5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30; 5'd19: a = 32'h00000518; 5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146; 5'd22: a = 32'h000000A3; 5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029; 5'd25: a = 32'h00000014; 5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005; 5'd28: a = 32'h00000003; 5'd29: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] v);
		logic signed [31:0] r;
		if (v > 42'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -42'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic w36_t sel_src(input logic [4:0] code, input w36_t cs [6],
			input w36_t pp [4], input w36_t d [4], input logic signed [31:0] rot [4],
			input logic signed [31:0] vec [3], input w36_t t [4]);
		w36_t r;
		case (code)
			S_CX:   r = cs[0];
			S_SX:   r = cs[1];
			S_CY:   r = cs[2];
			S_SY:   r = cs[3];
			S_CZ:   r = cs[4];
			S_SZ:   r = cs[5];
			S_CZCY: r = pp[0];
			S_SZSY: r = pp[1];
			S_CZSY: r = pp[2];
			S_SZCY: r = pp[3];
			S_D0:   r = d[0];
			S_D1:   r = d[1];
			S_D2:   r = d[2];
			S_D3:   r = d[3];
			S_Q0:   r = AW'(rot[0]);
			S_Q1:   r = AW'(rot[1]);
			S_Q2:   r = AW'(rot[2]);
			S_Q3:   r = AW'(rot[3]);
			S_N1:   r = -AW'(rot[1]);
			S_N2:   r = -AW'(rot[2]);
			S_N3:   r = -AW'(rot[3]);
			S_V0:   r = AW'(vec[0]);
			S_V1:   r = AW'(vec[1]);
			S_V2:   r = AW'(vec[2]);
			S_T0:   r = t[0];
			S_T1:   r = t[1];
			S_T2:   r = t[2];
			S_T3:   r = t[3];
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/quaternion_forward_kinematics_chain_unit.sv =====
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     in_valid / in_ready   req_type, vec_x..z, quat_w..z, angle_x..z
// output    out_valid / out_ready node_index, pos_x..z, rot_w..z
//
// A base item presents its result in the cycle right after its transfer. A joint item
// runs three 30-step CORDIC passes (one step per cycle) and then 52 products on one
// shift-add multiplier that retires one multiplier bit per cycle, after which its result
// becomes valid. One item is in flight at a time; in_ready is high only when idle.
// Reset puts the chain at the origin with the identity orientation and node 0.
// A stalled result holds its payload until the output transfer completes.
module quaternion_forward_kinematics_chain_unit
	import qfk_pkg::*;
#(
	parameter int MAX_JOINTS = 32,
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] quat_w,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         node_index,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] rot_w,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z
);

	// The node counter stops at the joint limit, and never above what six bits hold.
	localparam logic [5:0] NODE_CAP = (MAX_JOINTS > 63) ? 6'd63 : 6'(MAX_JOINTS);
	localparam int PHASE_SH = 31 - ANGLE_BITS;

	logic [1:0]         state_q;
	logic [5:0]         cnt_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] rot_q [4];
	logic signed [31:0] vec_q [3];
	logic [15:0]        ang_q [3];

	// CORDIC datapath.
	logic signed [33:0] cr_x_q, cr_y_q, cr_z_q;
	logic [4:0]         it_q;
	logic [1:0]         sel_q;

	// Intermediate values of the joint update.
	w36_t cs_q [6];
	w36_t pp_q [4];
	w36_t d_q [4];
	w36_t nq_q [3];
	w36_t t_q [4];

	// Shift-add multiplier and accumulator.
	logic [5:0]           pc_q;
	logic [5:0]           bit_q;
	logic signed [PW-1:0] ma_q;
	logic [BW-1:0]        mb_q;
	logic signed [PW-1:0] prod_q;
	logic signed [ACCW-1:0] acc_q;

	logic                   in_xfer;
	logic                   out_xfer;
	uop_t                   u;
	w36_t                   opa, opb;
	logic signed [PW-1:0]   rsum;
	logic signed [ACCW-1:0] rnd;
	logic signed [ACCW-1:0] acc_n;
	logic [15:0]            ang_sel;
	logic [23:0]            ang_ext;
	logic signed [ANGLE_BITS-1:0] ang_lo;
	logic signed [33:0]     phase;
	logic signed [33:0]     dx, dy, at;
	logic signed [33:0]     xn, yn, zn;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid && out_ready;

	assign node_index = cnt_q;
	assign pos_x = pos_q[0];
	assign pos_y = pos_q[1];
	assign pos_z = pos_q[2];
	assign rot_w = rot_q[0];
	assign rot_x = rot_q[1];
	assign rot_y = rot_q[2];
	assign rot_z = rot_q[3];

	// The half angle: low ANGLE_BITS bits, sign-extended, scaled so 2^32 is a turn.
	always_comb begin
		if (state_q == ST_IDLE) begin
			ang_sel = angle_x;
		end else begin
			case (sel_q)
				2'd0:    ang_sel = ang_q[1];
				default: ang_sel = ang_q[2];
			endcase
		end
		ang_ext = {8'd0, ang_sel};
		ang_lo  = ang_ext[ANGLE_BITS-1:0];
		phase   = 34'(ang_lo) <<< PHASE_SH;
	end

	// One rotation-mode CORDIC step.
	always_comb begin
		dx = cr_y_q >>> it_q;
		dy = cr_x_q >>> it_q;
		at = {2'b00, atan_lut(it_q)};
		if (cr_z_q >= 0) begin
			xn = cr_x_q - dx;
			yn = cr_y_q + dy;
			zn = cr_z_q - at;
		end else begin
			xn = cr_x_q + dx;
			yn = cr_y_q - dy;
			zn = cr_z_q + at;
		end
	end

	// Operand fetch, and the rounded product: floor((a*b + 2^29) / 2^30).
	always_comb begin
		u     = uop_rom(pc_q);
		opa   = sel_src(u.srca, cs_q, pp_q, d_q, rot_q, vec_q, t_q);
		opb   = sel_src(u.srcb, cs_q, pp_q, d_q, rot_q, vec_q, t_q);
		rsum  = prod_q + PW'(64'sd536870912);
		rnd   = ACCW'(rsum >>> 30);
		acc_n = u.sub ? (acc_q - rnd) : (acc_q + rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			for (int i = 0; i < 3; i++)
				pos_q[i] <= '0;
			rot_q[0] <= 32'sd1073741824;
			for (int i = 1; i < 4; i++)
				rot_q[i] <= '0;
			it_q  <= '0;
			sel_q <= '0;
			pc_q  <= '0;
			bit_q <= '0;
			acc_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (!req_type) begin
							pos_q[0] <= vec_x;
							pos_q[1] <= vec_y;
							pos_q[2] <= vec_z;
							rot_q[0] <= quat_w;
							rot_q[1] <= quat_x;
							rot_q[2] <= quat_y;
							rot_q[3] <= quat_z;
							cnt_q    <= '0;
							state_q  <= ST_OUT;
						end else begin
							vec_q[0] <= vec_x;
							vec_q[1] <= vec_y;
							vec_q[2] <= vec_z;
							ang_q[0] <= angle_x;
							ang_q[1] <= angle_y;
							ang_q[2] <= angle_z;
							cr_x_q   <= CORDIC_GAIN;
							cr_y_q   <= '0;
							cr_z_q   <= phase;
							it_q     <= '0;
							sel_q    <= '0;
							state_q  <= ST_CORD;
						end
					end
				end
				ST_CORD: begin
					if (it_q == CORDIC_LAST) begin
						cs_q[{sel_q, 1'b0}] <= AW'(xn);
						cs_q[{sel_q, 1'b1}] <= AW'(yn);
						it_q <= '0;
						if (sel_q == 2'd2) begin
							pc_q    <= '0;
							bit_q   <= '0;
							state_q <= ST_MUL;
						end else begin
							sel_q  <= sel_q + 2'd1;
							cr_x_q <= CORDIC_GAIN;
							cr_y_q <= '0;
							cr_z_q <= phase;
						end
					end else begin
						cr_x_q <= xn;
						cr_y_q <= yn;
						cr_z_q <= zn;
						it_q   <= it_q + 5'd1;
					end
				end
				ST_MUL: begin
					if (bit_q == '0) begin
						ma_q   <= PW'(opa);
						mb_q   <= BW'(opb);
						prod_q <= '0;
						bit_q  <= 6'd1;
					end else if (bit_q != MUL_FIN) begin
						// The top multiplier bit carries negative weight.
						if (mb_q[0])
							prod_q <= (bit_q == 6'(BW)) ? (prod_q - ma_q) : (prod_q + ma_q);
						ma_q  <= ma_q <<< 1;
						mb_q  <= mb_q >> 1;
						bit_q <= bit_q + 6'd1;
					end else begin
						bit_q <= '0;
						if (u.last) begin
							acc_q <= '0;
							case (u.dst)
								D_CZCY: pp_q[0] <= AW'(acc_n);
								D_SZSY: pp_q[1] <= AW'(acc_n);
								D_CZSY: pp_q[2] <= AW'(acc_n);
								D_SZCY: pp_q[3] <= AW'(acc_n);
								D_D0:   d_q[0]  <= AW'(acc_n);
								D_D1:   d_q[1]  <= AW'(acc_n);
								D_D2:   d_q[2]  <= AW'(acc_n);
								D_D3:   d_q[3]  <= AW'(acc_n);
								D_NQ0:  nq_q[0] <= AW'(acc_n);
								D_NQ1:  nq_q[1] <= AW'(acc_n);
								D_NQ2:  nq_q[2] <= AW'(acc_n);
								D_ROT: begin
									// All four new components are known: commit them together.
									rot_q[0] <= sat32(ACCW'(nq_q[0]));
									rot_q[1] <= sat32(ACCW'(nq_q[1]));
									rot_q[2] <= sat32(ACCW'(nq_q[2]));
									rot_q[3] <= sat32(acc_n);
								end
								D_T0: t_q[0] <= AW'(acc_n);
								D_T1: t_q[1] <= AW'(acc_n);
								D_T2: t_q[2] <= AW'(acc_n);
								D_T3: t_q[3] <= AW'(acc_n);
								D_P0: pos_q[0] <= sat32(ACCW'(pos_q[0]) + acc_n);
								D_P1: pos_q[1] <= sat32(ACCW'(pos_q[1]) + acc_n);
								D_P2: pos_q[2] <= sat32(ACCW'(pos_q[2]) + acc_n);
								default: ;
							endcase
						end else begin
							acc_q <= acc_n;
						end
						if (pc_q == LAST_UOP) begin
							if (cnt_q < NODE_CAP)
								cnt_q <= cnt_q + 6'd1;
							state_q <= ST_OUT;
						end else begin
							pc_q <= pc_q + 6'd1;
						end
					end
				end
				ST_OUT: begin
					if (out_xfer)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides open at once");
	a_node_cap: assert property (@(posedge clk) disable iff (!arst_n)
		node_index <= NODE_CAP)
		else $error("node index beyond its cap");
	a_base_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !req_type) |=> out_valid)
		else $error("base item result not presented in the next cycle");
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready)
		else $error("block not idle after output transfer");
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (acc_q == '0))
		else $error("accumulator not clear at item start");
`endif

endmodule

// ===== tb/sv/tb_quaternion_forward_kinematics_chain_unit.sv =====
`timescale 1ns / 1ps
module tb_quaternion_forward_kinematics_chain_unit;
	import qfk_pkg::*;

	// Item kinds on req_type.
	localparam logic KIND_BASE  = 1'b0;
	localparam logic KIND_JOINT = 1'b1;
	localparam int   CHAIN_CAP  = 32;
	localparam longint UNIT_Q30 = 64'sd1073741824;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] vx, vy, vz;
		logic signed [31:0] qw, qx, qy, qz;
		logic signed [15:0] ax, ay, az;
	} chain_item_t;

	typedef struct packed {
		logic [5:0]         idx;
		logic signed [31:0] px, py, pz;
		logic signed [31:0] rw, rx, ry, rz;
	} node_pose_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic signed [31:0] vec_x, vec_y, vec_z;
	logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
	logic signed [15:0] angle_x, angle_y, angle_z;
	logic               out_valid;
	logic               out_ready;
	logic [5:0]         node_index;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [31:0] rot_w, rot_x, rot_y, rot_z;

	quaternion_forward_kinematics_chain_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.node_index(node_index),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.rot_w(rot_w), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
	);

	// Mirror of the chain state, updated at each input transfer.
	longint     chain_pos [3];
	longint     chain_rot [4];
	int         chain_count;
	node_pose_t pending_poses [$];

	int errors;
	int items_sent;
	int poses_checked;
	int max_index_seen;
	// When set, neither side inserts idle cycles.
	bit no_idle;

	longint atan_turn [30] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous ceiling on the run time, including the random stalls on both sides.
	initial begin
		#200_000_000;
		$display("quaternion_forward_kinematics_chain_unit test failed");
		$finish;
	end

	// Q30 product, rounded half up, on a wide signed intermediate.
	function automatic longint q30_mul(input longint a, input longint b);
		logic signed [127:0] wa, wb, prod;
		wa = a;
		wb = b;
		prod = (wa * wb + (128'sd1 <<< 29)) >>> 30;
		return longint'(prod);
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Rotation-mode CORDIC on a half-angle phase where 2^32 is a full turn.
	function automatic void half_angle_cos_sin(input logic signed [15:0] ang,
			output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = 64'sd652032874;
		y = 0;
		z = longint'(ang) * 32768;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_turn[i];
			end else begin
				x += dx; y -= dy; z += atan_turn[i];
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic void hamilton(input longint a [4], input longint b [4],
			output longint o [4]);
		o[0] = q30_mul(a[0], b[0]) - q30_mul(a[1], b[1]) - q30_mul(a[2], b[2])
			- q30_mul(a[3], b[3]);
		o[1] = q30_mul(a[0], b[1]) + q30_mul(a[1], b[0]) + q30_mul(a[2], b[3])
			- q30_mul(a[3], b[2]);
		o[2] = q30_mul(a[0], b[2]) - q30_mul(a[1], b[3]) + q30_mul(a[2], b[0])
			+ q30_mul(a[3], b[1]);
		o[3] = q30_mul(a[0], b[3]) + q30_mul(a[1], b[2]) - q30_mul(a[2], b[1])
			+ q30_mul(a[3], b[0]);
	endfunction

	// Advances the mirrored chain by one item and returns the node it emits.
	function automatic node_pose_t advance_chain(input chain_item_t it);
		longint cx, sx, cy, sy, cz, sz, czcy, szsy, czsy, szcy;
		longint dq [4], nq [4], lv [4], cj [4], tq [4], rq [4];
		node_pose_t p;
		if (it.kind == KIND_BASE) begin
			chain_pos = '{it.vx, it.vy, it.vz};
			chain_rot = '{it.qw, it.qx, it.qy, it.qz};
			chain_count = 0;
		end else begin
			half_angle_cos_sin(it.ax, cx, sx);
			half_angle_cos_sin(it.ay, cy, sy);
			half_angle_cos_sin(it.az, cz, sz);
			czcy = q30_mul(cz, cy);
			szsy = q30_mul(sz, sy);
			czsy = q30_mul(cz, sy);
			szcy = q30_mul(sz, cy);
			dq[0] = q30_mul(czcy, cx) + q30_mul(szsy, sx);
			dq[1] = q30_mul(czcy, sx) - q30_mul(szsy, cx);
			dq[2] = q30_mul(czsy, cx) + q30_mul(szcy, sx);
			dq[3] = q30_mul(szcy, cx) - q30_mul(czsy, sx);
			hamilton(chain_rot, dq, nq);
			for (int i = 0; i < 4; i++)
				chain_rot[i] = clamp32(nq[i]);
			// The link is rotated by the orientation just stored.
			lv = '{0, longint'(it.vx), longint'(it.vy), longint'(it.vz)};
			cj[0] = chain_rot[0];
			for (int i = 1; i < 4; i++)
				cj[i] = -chain_rot[i];
			hamilton(chain_rot, lv, tq);
			hamilton(tq, cj, rq);
			for (int i = 0; i < 3; i++)
				chain_pos[i] = clamp32(chain_pos[i] + rq[i + 1]);
			if (chain_count < CHAIN_CAP)
				chain_count++;
		end
		p.idx = 6'(chain_count);
		p.px = chain_pos[0][31:0];
		p.py = chain_pos[1][31:0];
		p.pz = chain_pos[2][31:0];
		p.rw = chain_rot[0][31:0];
		p.rx = chain_rot[1][31:0];
		p.ry = chain_rot[2][31:0];
		p.rz = chain_rot[3][31:0];
		return p;
	endfunction

	// Offers one item after a random gap and waits for its transfer.
	task automatic send_item(input chain_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= it.kind;
		vec_x <= it.vx; vec_y <= it.vy; vec_z <= it.vz;
		quat_w <= it.qw; quat_x <= it.qx; quat_y <= it.qy; quat_z <= it.qz;
		angle_x <= it.ax; angle_y <= it.ay; angle_z <= it.az;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_poses.push_back(advance_chain(it));
		items_sent++;
	endtask

	// Waits until every emitted node has been checked.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_poses.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] random_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
		endcase
	endfunction

	function automatic chain_item_t make_base(input logic signed [31:0] px, py, pz,
			input logic signed [31:0] qw, qx, qy, qz);
		chain_item_t it;
		it.kind = KIND_BASE;
		it.vx = px; it.vy = py; it.vz = pz;
		it.qw = qw; it.qx = qx; it.qy = qy; it.qz = qz;
		// Angles are ignored on a base item, so they carry noise.
		it.ax = 16'($urandom); it.ay = 16'($urandom); it.az = 16'($urandom);
		return it;
	endfunction

	function automatic chain_item_t make_joint(input logic signed [31:0] lx, ly, lz,
			input logic signed [15:0] ax, ay, az);
		chain_item_t it;
		it.kind = KIND_JOINT;
		it.vx = lx; it.vy = ly; it.vz = lz;
		// Quaternion fields are ignored on a joint item.
		it.qw = $urandom; it.qx = $urandom; it.qy = $urandom; it.qz = $urandom;
		it.ax = ax; it.ay = ay; it.az = az;
		return it;
	endfunction

	function automatic chain_item_t random_joint();
		return make_joint(random_word(), random_word(), random_word(),
			16'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	function automatic chain_item_t random_base();
		if ($urandom_range(0, 3) == 0)
			return make_base(random_word(), random_word(), random_word(),
				random_word(), random_word(), random_word(), random_word());
		return make_base(random_word(), random_word(), random_word(),
			32'(UNIT_Q30), 0, 0, 0);
	endfunction

	// Result side: random stall before each transfer, then a field-wise check.
	function automatic void check_field(input string name, input longint expv,
			input longint actv);
		if (expv != actv) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, expv, actv);
			errors++;
		end
	endfunction

	initial begin
		node_pose_t e;
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (pending_poses.size() == 0) begin
				$display("%0t: unexpected node %0d with nothing pending", $time,
					node_index);
				errors++;
			end else begin
				e = pending_poses.pop_front();
				check_field("node_index", e.idx, node_index);
				check_field("pos_x", e.px, pos_x);
				check_field("pos_y", e.py, pos_y);
				check_field("pos_z", e.pz, pos_z);
				check_field("rot_w", e.rw, rot_w);
				check_field("rot_x", e.rx, rot_x);
				check_field("rot_y", e.ry, rot_y);
				check_field("rot_z", e.rz, rot_z);
				if (int'(node_index) > max_index_seen)
					max_index_seen = node_index;
			end
			poses_checked++;
		end
	end

	// A joint arriving before any base works from the reset pose.
	task automatic test_joint_from_reset();
		send_item(make_joint(32'sh00010000, 0, 0, 0, 0, 0));
		send_item(make_joint(0, 32'sh00020000, 0, 16'sd8192, 0, 0));
	endtask

	// Field extremes, angle extremes and a non-unit base orientation.
	task automatic test_directed_extremes();
		send_item(make_base(0, 0, 0, 32'(UNIT_Q30), 0, 0, 0));
		send_item(make_joint(32'sh7fffffff, 32'sh80000000, 0, 16'sh7fff, 0, 0));
		send_item(make_joint(0, 0, 32'sh7fffffff, 16'sh8000, 16'sh8000, 16'sh8000));
		send_item(make_joint(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			16'sh7fff, 16'sh7fff, 16'sh7fff));
		send_item(make_joint(32'sh80000000, 32'sh80000000, 32'sh80000000,
			0, 16'sh4000, 16'shc000));
		// Position saturation: start near the edge and push outward.
		send_item(make_base(32'sh7fff0000, 32'sh80010000, 0, 32'(UNIT_Q30), 0, 0, 0));
		send_item(make_joint(32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0));
		// Non-unit base quaternion used as given, large enough to saturate.
		send_item(make_base(0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff));
		send_item(make_joint(32'sh00010000, 32'sh00010000, 32'sh00010000,
			16'sd100, 16'sd200, 16'sd300));
		send_item(make_base(1, 2, 3, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000));
		send_item(make_joint(0, 0, 0, 16'sh8000, 16'sh7fff, 16'sh0001));
		send_item(make_base(32'sh12345678, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0));
		send_item(make_joint(32'sh00100000, 0, 0, 16'shffff, 16'sh0001, 16'sh8001));
	endtask

	// A chain longer than the node cap keeps its index at the cap.
	task automatic test_long_chain();
		send_item(make_base(0, 0, 0, 32'(UNIT_Q30), 0, 0, 0));
		for (int i = 0; i < CHAIN_CAP + 6; i++)
			send_item(make_joint($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000, 0,
				32'sh8000, 16'($urandom_range(0, 2000)), 0, 16'($urandom_range(0, 2000))));
	endtask

	// Random chains with random content, with some bare noise mixed in.
	task automatic test_random_chains(input int count);
		int sent, len;
		sent = 0;
		while (sent < count) begin
			no_idle = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 7) == 0) begin
				send_item($urandom_range(0, 1) ? random_joint() : random_base());
				sent++;
			end else begin
				send_item(random_base());
				len = $urandom_range(1, 40);
				for (int i = 0; i < len; i++)
					send_item(random_joint());
				sent += len + 1;
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		errors = 0;
		items_sent = 0;
		poses_checked = 0;
		max_index_seen = 0;
		no_idle = 1'b0;
		chain_pos = '{0, 0, 0};
		chain_rot = '{UNIT_Q30, 0, 0, 0};
		chain_count = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = KIND_BASE;
		vec_x = 0; vec_y = 0; vec_z = 0;
		quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
		angle_x = 0; angle_y = 0; angle_z = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_joint_from_reset();
		test_directed_extremes();
		// Hold the sender until the block has emptied its output.
		drain_results();
		test_long_chain();
		drain_results();
		test_random_chains(1800);
		drain_results();
		repeat (20) @(posedge clk);
		if (pending_poses.size() != 0) begin
			$display("%0t: %0d nodes never emitted", $time, pending_poses.size());
			errors++;
		end

		$display("Sent %0d base and joint items, checked %0d node poses.",
			items_sent, poses_checked);
		$display("Highest node index observed: %0d.", max_index_seen);
		if (errors == 0)
			$display("quaternion_forward_kinematics_chain_unit test passed");
		else
			$display("quaternion_forward_kinematics_chain_unit test failed");
		$finish;
	end

endmodule
